/* rtl/scc_pkg.sv */
// Shared types, codes and constants for the strong connectivity checker.
package scc_pkg;

    localparam int MAX_VERTICES = 64;

    localparam int OP_W  = 2;
    localparam int VID_W = 6;
    localparam int CFG_W = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_WALK_INIT,
        ST_POP,
        ST_STK_WAIT,
        ST_ROW_RD,
        ST_ROW_LOAD,
        ST_SCAN,
        ST_WALK_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic add_rd;
        logic add_wr;
        logic walk_init;
        logic pop;
        logic load_cur;
        logic load_row;
        logic scan;
        logic walk_end;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            add_ok;
        logic            depth_zero;
        logic            scan_last;
        logic            all_reached;
        logic            reverse;
        logic            out_busy;
    } status_t;

endpackage

/* rtl/strong_connectivity_check.sv */
// Top level of the strong connectivity checker: controller, datapath and ports.
//
// Holds a directed graph of up to MAX_VERTICES vertices as two bit matrices (rows and
// columns) in RAM with per-row valid flags, so reset and a clear word take effect at
// once with no clearing pass. An add-edge word passes through decode, row read and
// row write; a clear word and an ignored word end after decode. A check word runs a
// depth-first walk from vertex 0 over the forward edges and, if every active vertex
// was reached, a second walk over the reversed edges; each walk scans one matrix row
// for every vertex it reaches, one vertex per cycle in the datapath. One input word
// is worked on at a time; the result word sits in an output register and a new
// input word is taken while it waits.
module strong_connectivity_check #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_W-1:0]       cfg_data,       // vertex_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation[1:0], src_vertex[7:2], dst_vertex[13:8], zero [15:14]
    input  logic [scc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // strongly_connected[0], forward_all_reached[1], reverse_all_reached[2], zero [7:3]
    output logic [scc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import scc_pkg::*;

    cmd_t    cmd;
    status_t st;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    scc_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/scc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scc_ctrl.sv */
// Controller state machine sequencing edge updates and the two graph walks.
module scc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  scc_pkg::status_t st,
    output scc_pkg::cmd_t    cmd
);

    import scc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (st.op)
                    OP_ADD_EDGE: state_next = st.add_ok ? ST_ADD_RD : ST_IDLE;
                    OP_CHECK:    state_next = ST_WALK_INIT;
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_ADD_RD:
            begin
                cmd.add_rd = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_POP;
            end
            ST_POP:
            begin
                if (st.depth_zero)
                begin
                    state_next = ST_WALK_END;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_STK_WAIT;
                end
            end
            ST_STK_WAIT:
            begin
                cmd.load_cur = 1'b1;
                state_next   = ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_LOAD;
            end
            ST_ROW_LOAD:
            begin
                cmd.load_row = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = ST_POP;
                end
            end
            ST_WALK_END:
            begin
                cmd.walk_end = 1'b1;
                state_next   = (!st.reverse && st.all_reached) ? ST_WALK_INIT : ST_DONE;
            end
            ST_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/scc_dpath.sv */
// Datapath: adjacency matrices, walk stack, visited marks and result register.
module scc_dpath #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_W-1:0]       cfg_data,
    input  logic [scc_pkg::IN_TDATA_W-1:0]  in_data,
    input  scc_pkg::cmd_t                   cmd,
    output scc_pkg::status_t                st,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scc_pkg::OUT_TDATA_W-1:0] out_data
);

    import scc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]        vcount_reg;
    logic [NW-1:0]           vc_ext;
    logic [CW-1:0]           n_act;

    logic [OP_W-1:0]         op_reg;
    logic [VID_W-1:0]        src_reg;
    logic [VID_W-1:0]        dst_reg;

    logic [MAX_VERTICES-1:0] fwd_valid_reg;
    logic [MAX_VERTICES-1:0] rev_valid_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] row_reg;
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           marks_reg;
    logic [VW-1:0]           scan_reg;
    logic [VW-1:0]           cur_reg;
    logic                    reverse_reg;
    logic                    fwd_ok_reg;
    logic                    rev_ok_reg;
    logic                    out_valid_reg;
    logic [2:0]              out_bits_reg;

    logic [VW-1:0]           src_idx;
    logic [VW-1:0]           dst_idx;
    logic [MAX_VERTICES-1:0] fwd_q;
    logic [MAX_VERTICES-1:0] rev_q;
    logic [MAX_VERTICES-1:0] fwd_row;
    logic [MAX_VERTICES-1:0] rev_row;
    logic [MAX_VERTICES-1:0] fwd_wdata;
    logic [MAX_VERTICES-1:0] rev_wdata;
    logic [VW-1:0]           fwd_raddr;
    logic [VW-1:0]           rev_raddr;
    logic                    push;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr;
    logic [VW-1:0]           stk_wdata;
    logic [VW-1:0]           stk_raddr;
    logic [VW-1:0]           stk_q;
    logic                    all_reached;

    assign cfg_ready = 1'b1;

    assign vc_ext = NW'(vcount_reg);

    always_comb
    begin
        if (vc_ext == '0)
        begin
            n_act = CW'(1);
        end
        else if (vc_ext > NW'(MAX_VERTICES))
        begin
            n_act = CW'(MAX_VERTICES);
        end
        else
        begin
            n_act = CW'(vc_ext);
        end
    end

    assign src_idx = VW'(src_reg);
    assign dst_idx = VW'(dst_reg);

    assign fwd_raddr = cmd.add_rd ? src_idx : cur_reg;
    assign rev_raddr = cmd.add_rd ? dst_idx : cur_reg;

    assign fwd_row   = fwd_valid_reg[cur_reg] ? fwd_q : '0;
    assign rev_row   = rev_valid_reg[cur_reg] ? rev_q : '0;
    assign fwd_wdata = (fwd_valid_reg[src_idx] ? fwd_q : '0)
                     | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << dst_idx);
    assign rev_wdata = (rev_valid_reg[dst_idx] ? rev_q : '0)
                     | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_idx);

    assign push      = cmd.scan && row_reg[scan_reg] && !visited_reg[scan_reg];
    assign stk_we    = cmd.walk_init || push;
    assign stk_waddr = cmd.walk_init ? '0 : VW'(depth_reg);
    assign stk_wdata = cmd.walk_init ? '0 : scan_reg;
    assign stk_raddr = VW'(depth_reg - CW'(1));

    assign all_reached = (marks_reg == n_act);

    scc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (cmd.add_wr),
        .waddr (src_idx),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_q)
    );

    scc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rev_ram (
        .clk   (clk),
        .we    (cmd.add_wr),
        .waddr (dst_idx),
        .wdata (rev_wdata),
        .raddr (rev_raddr),
        .rdata (rev_q)
    );

    scc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VERTEX_COUNT_RESET;
            fwd_valid_reg <= '0;
            rev_valid_reg <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            marks_reg     <= '0;
            reverse_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                fwd_valid_reg <= '0;
                rev_valid_reg <= '0;
            end
            if (cmd.add_wr)
            begin
                fwd_valid_reg[src_idx] <= 1'b1;
                rev_valid_reg[dst_idx] <= 1'b1;
            end
            if (cmd.capture)
            begin
                reverse_reg <= 1'b0;
            end
            if (cmd.walk_init)
            begin
                visited_reg <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
                depth_reg   <= CW'(1);
                marks_reg   <= CW'(1);
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_reg - CW'(1);
            end
            if (push)
            begin
                visited_reg[scan_reg] <= 1'b1;
                depth_reg             <= depth_reg + CW'(1);
                marks_reg             <= marks_reg + CW'(1);
            end
            if (cmd.walk_end && !reverse_reg && all_reached)
            begin
                reverse_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data[OP_W-1:0];
            src_reg <= in_data[OP_W+VID_W-1:OP_W];
            dst_reg <= in_data[OP_W+2*VID_W-1:OP_W+VID_W];
        end
        if (cmd.load_cur)
        begin
            cur_reg <= stk_q;
        end
        if (cmd.load_row)
        begin
            row_reg  <= reverse_reg ? rev_row : fwd_row;
            scan_reg <= '0;
        end
        else if (cmd.scan)
        begin
            scan_reg <= scan_reg + VW'(1);
        end
        if (cmd.walk_end)
        begin
            if (reverse_reg)
            begin
                rev_ok_reg <= all_reached;
            end
            else
            begin
                fwd_ok_reg <= all_reached;
                rev_ok_reg <= 1'b0;
            end
        end
        if (cmd.load_out)
        begin
            out_bits_reg <= {rev_ok_reg, fwd_ok_reg, fwd_ok_reg && rev_ok_reg};
        end
    end

    assign st.op          = op_reg;
    assign st.add_ok      = (NW'(src_reg) < NW'(n_act)) && (NW'(dst_reg) < NW'(n_act));
    assign st.depth_zero  = (depth_reg == '0);
    assign st.scan_last   = (CW'(scan_reg) == (n_act - CW'(1)));
    assign st.all_reached = all_reached;
    assign st.reverse     = reverse_reg;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W-3){1'b0}}, out_bits_reg};

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (depth_reg < CW'(MAX_VERTICES)))
        else $error("walk stack overflow");

    a_marks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (marks_reg < n_act))
        else $error("more vertices marked than active");

    a_root_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_init |=> visited_reg[0] && (depth_reg == CW'(1)))
        else $error("walk did not start from vertex zero");

    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_bits_reg[0] == (out_bits_reg[1] && out_bits_reg[2]))
                          && (!out_bits_reg[2] || out_bits_reg[1]))
        else $error("inconsistent connectivity result");

endmodule

/* tb/strong_connectivity_check_test.sv */
// Self-checking testbench for the strong connectivity checker: directed table, random graphs.
module strong_connectivity_check_test;

    import scc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 50000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_WORDS = 95;
    localparam int DIRECTED_ROWS = 25;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic reverse_all;
        logic forward_all;
        logic connected;
    } verdict_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] setting;
        logic [OP_W-1:0]  op;
        logic [VID_W-1:0] src;
        logic [VID_W-1:0] dst;
        logic             typed;
        verdict_t         want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [MAX_VERTICES-1:0] edge_rows [MAX_VERTICES];
    logic [CFG_W-1:0]        vertex_setting;
    verdict_t                pending_verdicts [$];
    int                      mismatch_count;
    int                      quiet_cycles;
    int                      counted_words;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    verdict_t                got_verdict;
    verdict_t                want_verdict;

    dir_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b000},
        '{ROW_CFG,  7'd1,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b111},
        '{ROW_CFG,  7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b111},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd63, 6'd63, 1'b0, 3'b000},
        '{ROW_CFG,  7'd2,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd1,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b010},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd1,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd1,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b111},
        '{ROW_WORD, 7'd0,   OP_UNUSED,   6'd63, 6'd63, 1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd63, 1'b0, 3'b000},
        '{ROW_CFG,  7'd127, OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd63, 6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd63, 1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_CFG,  7'd2,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CLEAR,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b000},
        '{ROW_CFG,  7'd64,  OP_CHECK,    6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_UNUSED,   6'd0,  6'd0,  1'b0, 3'b000},
        '{ROW_WORD, 7'd0,   OP_CHECK,    6'd0,  6'd0,  1'b1, 3'b000}
    };

    strong_connectivity_check DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int active_vertices();
        if (vertex_setting == '0)
            return 1;
        if (vertex_setting > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(vertex_setting);
    endfunction

    function automatic logic walk_covers(input int n, input logic reversed);
        logic [MAX_VERTICES-1:0] seen;
        int                      stack [MAX_VERTICES];
        int                      depth;
        int                      v;
        int                      w;
        logic                    linked;
        seen = '0;
        seen[0] = 1'b1;
        stack[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            depth = depth - 1;
            v = stack[depth];
            for (w = 0; w < n; w++)
            begin
                linked = reversed ? edge_rows[w][v] : edge_rows[v][w];
                if (linked && !seen[w] && depth < MAX_VERTICES)
                begin
                    seen[w] = 1'b1;
                    stack[depth] = w;
                    depth = depth + 1;
                end
            end
        end
        for (v = 0; v < n; v++)
            if (!seen[v])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic verdict_t check_connectivity();
        verdict_t verdict;
        int       n;
        n = active_vertices();
        verdict.forward_all = walk_covers(n, 1'b0);
        verdict.reverse_all = verdict.forward_all ? walk_covers(n, 1'b1) : 1'b0;
        verdict.connected = verdict.forward_all && verdict.reverse_all;
        return verdict;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [VID_W-1:0] src,
                             input logic [VID_W-1:0] dst, input logic typed,
                             input verdict_t want);
        int       r;
        int       n;
        verdict_t next_verdict;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - OP_W - 2 * VID_W){1'b0}}, dst, src, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n = active_vertices();
        case (op)
            OP_ADD_EDGE:
                if (src < n && dst < n)
                    edge_rows[src][dst] = 1'b1;
            OP_CLEAR:
                for (r = 0; r < MAX_VERTICES; r++)
                    edge_rows[r] = '0;
            OP_CHECK:
            begin
                next_verdict = typed ? want : check_connectivity();
                pending_verdicts = {pending_verdicts, next_verdict};
            end
            default:
                ;
        endcase
    endtask

    task automatic wait_for_verdicts(input int settle);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_vertex_count(input logic [CFG_W-1:0] value);
        wait_for_verdicts(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vertex_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0)
            send_word(OP_UNUSED, VID_W'($urandom_range(0, 63)), VID_W'($urandom_range(0, 63)),
                      1'b0, '0);
        else
            send_word(OP_ADD_EDGE, VID_W'($urandom_range(0, 63)),
                      VID_W'($urandom_range(0, 63)), 1'b0, '0);
    endtask

    task automatic add_counted_edge(input int src, input int dst);
        if ($urandom_range(0, 11) == 0)
            send_noise();
        send_word(OP_ADD_EDGE, VID_W'(src), VID_W'(dst), 1'b0, '0);
        counted_words++;
    endtask

    task automatic build_and_check();
        int order [MAX_VERTICES];
        int n;
        int i;
        int j;
        int t;
        int style;
        int dropped;
        int extras;
        n = active_vertices();
        if ($urandom_range(0, 4) != 0)
        begin
            send_word(OP_CLEAR, VID_W'($urandom_range(0, 63)), VID_W'($urandom_range(0, 63)),
                      1'b0, '0);
            counted_words++;
        end
        for (i = 0; i < n; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        style = $urandom_range(0, 3);
        dropped = (style == 2) ? $urandom_range(0, n - 1) : -1;
        if (style == 3)
            extras = $urandom_range(1, 2 * n);
        else
        begin
            extras = $urandom_range(0, n);
            for (i = 0; i < n; i++)
                if (i != dropped)
                    add_counted_edge(order[i], order[(i + 1) % n]);
        end
        for (i = 0; i < extras; i++)
        begin
            add_counted_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            if ($urandom_range(0, 19) == 0)
            begin
                send_word(OP_CHECK, '0, '0, 1'b0, '0);
                counted_words++;
            end
        end
        send_word(OP_CHECK, VID_W'($urandom_range(0, 63)), VID_W'($urandom_range(0, 63)),
                  1'b0, '0);
        counted_words++;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_verdict = m_axis_tdata[2:0];
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("result word %b with nothing expected", got_verdict));
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.connected !== want_verdict.connected)
                    report_mismatch($sformatf("strongly_connected %b, expected %b",
                                              got_verdict.connected, want_verdict.connected));
                if (got_verdict.forward_all !== want_verdict.forward_all)
                    report_mismatch($sformatf("forward_all_reached %b, expected %b",
                                              got_verdict.forward_all, want_verdict.forward_all));
                if (got_verdict.reverse_all !== want_verdict.reverse_all)
                    report_mismatch($sformatf("reverse_all_reached %b, expected %b",
                                              got_verdict.reverse_all, want_verdict.reverse_all));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("strong_connectivity_check test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int i;
        int phase;
        int rounds;
        int phase_setting [9];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        counted_words = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        vertex_setting = VERTEX_COUNT_RESET;
        for (i = 0; i < MAX_VERTICES; i++)
            edge_rows[i] = '0;
        phase_setting = '{3, 64, 0, 127, 6, 1, 2, 65, 9};
        phase_setting[8] = $urandom_range(3, 12);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed[i].kind == ROW_CFG)
                write_vertex_count(directed[i].setting);
            else
                send_word(directed[i].op, directed[i].src, directed[i].dst,
                          directed[i].typed, directed[i].want);
        end

        for (phase = 0; phase < 9; phase++)
        begin
            write_vertex_count(CFG_W'(phase_setting[phase]));
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            counted_words = 0;
            rounds = 0;
            while (counted_words < PHASE_WORDS)
            begin
                build_and_check();
                rounds++;
                // hold the sender until every verdict is back
                if (rounds == 1 || $urandom_range(0, 7) == 0)
                    wait_for_verdicts(0);
            end
        end

        wait_for_verdicts(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("strong_connectivity_check test passed");
        else
            $display("strong_connectivity_check test failed");
        $finish;
    end

endmodule
